/* design/hexlfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hexlfr_pkg
// Types, codes and helpers for the hex ASCII length frame receiver.
// ----------------------------------------------------------------------------
package hexlfr_pkg;

    typedef enum logic [1:0] {
        STATUS_DATA       = 2'd0,
        STATUS_RESET_MARK = 2'd1,
        STATUS_ZERO_LEN   = 2'd2,
        STATUS_OVERRUN    = 2'd3
    } status_t;

    localparam logic [7:0] LEN_RESET_MARK   = 8'hFF;
    localparam logic [7:0] LEN_ZERO         = 8'h00;
    localparam logic [7:0] BUFFER_SIZE_INIT = 8'd64;

    // Register index of buffer_size.
    localparam logic REG_BUFFER_SIZE = 1'b0;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        status_t    status;
        logic       last_of_frame;
    } result_t;

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

/* design/hex_ascii_length_frame_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_ascii_length_frame_receiver_core
// Pairs hex characters into bytes and tracks length-prefixed frames.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------------
//  char      | in        | char_valid/char_stall| ascii_char
//  byte      | out       | byte_valid/byte_stall| byte_value, byte_index,
//            |           |                      | status, last_of_frame
//  apb       | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  One character a cycle while char_stall is low. A byte beat is registered
//  into the output register once its second character is taken; a skid
//  register holds one more beat while the byte side stalls, and char_stall
//  rises only while the skid register is full. Reset clears the nibble,
//  count and frame state and sets buffer_size to 64.
// ----------------------------------------------------------------------------
module hex_ascii_length_frame_receiver_core
    import hexlfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] ascii_char,

    output logic       byte_valid,
    input  logic       byte_stall,
    output logic [7:0] byte_value,
    output logic [7:0] byte_index,
    output logic [1:0] status,
    output logic       last_of_frame,

    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic [7:0] buffer_size_reg;
    logic       nibble_pending_reg, nibble_pending_next;
    logic [3:0] high_nibble_reg,    high_nibble_next;
    logic [7:0] byte_count_reg,     byte_count_next;
    logic [7:0] frame_length_reg,   frame_length_next;

    logic       out_valid_reg,  out_valid_next;
    result_t    out_data_reg,   out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    skid_data_reg,  skid_data_next;

    logic       accept;
    logic       res_valid;
    result_t    res;
    logic [3:0] nib;
    logic [7:0] value;
    logic [7:0] count_inc;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);
    assign prdata    = (paddr[2] == REG_BUFFER_SIZE) ? {24'd0, buffer_size_reg} : 32'd0;

    assign char_stall = skid_valid_reg;
    assign accept     = char_valid && !skid_valid_reg;

    assign nib       = hex_nibble(ascii_char);
    assign value     = {high_nibble_reg, nib};
    assign count_inc = byte_count_reg + 8'd1;
    assign res_valid = accept && nibble_pending_reg;

    always_comb
    begin
        nibble_pending_next = nibble_pending_reg;
        high_nibble_next    = high_nibble_reg;
        byte_count_next     = byte_count_reg;
        frame_length_next   = frame_length_reg;
        res.byte_value      = value;
        res.byte_index      = byte_count_reg;
        res.status          = STATUS_DATA;
        res.last_of_frame   = 1'b0;

        if (accept)
        begin
            if (!nibble_pending_reg)
            begin
                high_nibble_next    = nib;
                nibble_pending_next = 1'b1;
            end
            else
            begin
                nibble_pending_next = 1'b0;
                if (byte_count_reg == 8'd0)
                begin
                    if (value == LEN_ZERO)
                    begin
                        res.status = STATUS_ZERO_LEN;
                    end
                    else if (value == LEN_RESET_MARK)
                    begin
                        res.status = STATUS_RESET_MARK;
                    end
                    else
                    begin
                        frame_length_next = value;
                        if (value == 8'd1)
                        begin
                            res.last_of_frame = 1'b1;
                        end
                        else
                        begin
                            byte_count_next = 8'd1;
                        end
                    end
                end
                else if (count_inc == buffer_size_reg)
                begin
                    // drop the frame
                    res.status      = STATUS_OVERRUN;
                    byte_count_next = 8'd0;
                end
                else if (count_inc == frame_length_reg)
                begin
                    res.last_of_frame = 1'b1;
                    byte_count_next   = 8'd0;
                end
                else
                begin
                    byte_count_next = count_inc;
                end
            end
        end
    end

    // Output register with one skid beat behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !byte_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg    <= BUFFER_SIZE_INIT;
            nibble_pending_reg <= 1'b0;
            high_nibble_reg    <= 4'd0;
            byte_count_reg     <= 8'd0;
            frame_length_reg   <= 8'd0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                buffer_size_reg <= pwdata[7:0];
            end
            nibble_pending_reg <= nibble_pending_next;
            high_nibble_reg    <= high_nibble_next;
            byte_count_reg     <= byte_count_next;
            frame_length_reg   <= frame_length_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign byte_valid    = out_valid_reg;
    assign byte_value    = out_data_reg.byte_value;
    assign byte_index    = out_data_reg.byte_index;
    assign status        = out_data_reg.status;
    assign last_of_frame = out_data_reg.last_of_frame;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex ASCII length frame receiver. A character
// driver feeds a queue of directed and random frames through the valid/stall
// port. A local decoder predicts each byte beat. A monitor compares every beat
// field by field and stalls at random, with one long hold-off. buffer_size is
// rewritten over the APB port between phases, and read back.
// ----------------------------------------------------------------------------
module tb_top
    import hexlfr_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER_BEATS = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  ascii_char = 8'd0;

    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  byte_value;
    logic [7:0]  byte_index;
    logic [1:0]  status;
    logic        last_of_frame;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Decoder state mirrored by the bench.
    logic        pair_open = 1'b0;
    logic [3:0]  held_nibble = 4'd0;
    logic [7:0]  frame_count = 8'd0;
    logic [7:0]  frame_len = 8'd0;
    logic [7:0]  buf_size = BUFFER_SIZE_INIT;

    logic [7:0]  char_queue[$];
    result_t     expected_bytes[$];
    int          chars_queued = 0;
    int          beats_seen = 0;
    int          fail_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    bit          steady = 1'b0;
    int          cycle_count = 0;

    hex_ascii_length_frame_receiver_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_stall    (char_stall),
        .ascii_char    (ascii_char),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .byte_index    (byte_index),
        .status        (status),
        .last_of_frame (last_of_frame),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [3:0] char_to_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= "0" && c <= "9")
            begin
                d = c - "0";
            end
            else if (c >= "A" && c <= "F")
            begin
                d = c - "A" + 8'd10;
            end
            else if (c >= "a" && c <= "f")
            begin
                d = c - "a" + 8'd10;
            end
            return d[3:0];
        end
    endfunction

    task automatic decode_char(input logic [7:0] c);
        logic [3:0] nib;
        logic [7:0] val;
        logic [7:0] nxt;
        result_t    r;
        begin
            nib = char_to_nibble(c);
            if (!pair_open)
            begin
                held_nibble = nib;
                pair_open = 1'b1;
            end
            else
            begin
                pair_open = 1'b0;
                val = {held_nibble, nib};
                r.byte_value = val;
                r.status = STATUS_DATA;
                r.last_of_frame = 1'b0;
                if (frame_count == 8'd0)
                begin
                    r.byte_index = 8'd0;
                    if (val == LEN_ZERO)
                    begin
                        r.status = STATUS_ZERO_LEN;
                    end
                    else if (val == LEN_RESET_MARK)
                    begin
                        r.status = STATUS_RESET_MARK;
                    end
                    else
                    begin
                        frame_len = val;
                        // a length of one is the whole frame
                        if (val == 8'd1)
                        begin
                            r.last_of_frame = 1'b1;
                        end
                        else
                        begin
                            frame_count = 8'd1;
                        end
                    end
                end
                else
                begin
                    r.byte_index = frame_count;
                    nxt = frame_count + 8'd1;
                    // overrun wins over completion
                    if (nxt == buf_size)
                    begin
                        r.status = STATUS_OVERRUN;
                        frame_count = 8'd0;
                    end
                    else if (nxt == frame_len)
                    begin
                        r.last_of_frame = 1'b1;
                        frame_count = 8'd0;
                    end
                    else
                    begin
                        frame_count = nxt;
                    end
                end
                expected_bytes.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            ascii_char <= 8'd0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                decode_char(ascii_char);
            end
            // hold a stalled beat, otherwise offer the next one or idle
            if (!char_valid || !char_stall)
            begin
                if (char_queue.size() > 0 && (steady || $urandom_range(99) >= 32))
                begin
                    char_valid <= 1'b1;
                    ascii_char <= char_queue.pop_front();
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte monitor
    // ------------------------------------------------------------------
    task automatic check_byte();
        result_t r;
        begin
            beats_seen++;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected byte beat: value %02h index %0d status %0d last %0b",
                       byte_value, byte_index, status, last_of_frame);
                fail_count++;
            end
            else
            begin
                r = expected_bytes.pop_front();
                if (byte_value !== r.byte_value)
                begin
                    $error("byte_value: expected %02h, got %02h", r.byte_value, byte_value);
                    fail_count++;
                end
                if (byte_index !== r.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d", r.byte_index, byte_index);
                    fail_count++;
                end
                if (status !== r.status)
                begin
                    $error("status: expected %0d, got %0d", r.status, status);
                    fail_count++;
                end
                if (last_of_frame !== r.last_of_frame)
                begin
                    $error("last_of_frame: expected %0b, got %0b",
                           r.last_of_frame, last_of_frame);
                    fail_count++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_stall <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                check_byte();
            end
            // one long hold-off so the skid fills and the char side stalls
            if (!hold_done && beats_seen >= HOLD_AFTER_BEATS)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                byte_stall <= 1'b1;
            end
            else
            begin
                byte_stall <= !steady && ($urandom_range(99) < 32);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c);
        begin
            char_queue.push_back(c);
            chars_queued++;
        end
    endtask

    task automatic push_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
            begin
                push_char(s[i]);
            end
        end
    endtask

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        begin
            if (n < 4'd10)
            begin
                return 8'h30 + n;
            end
            if ($urandom_range(1) == 1)
            begin
                return "A" + n - 8'd10;
            end
            return "a" + n - 8'd10;
        end
    endfunction

    // Mostly clean hex pairs; now and then a stray character or a dropped one.
    task automatic push_byte(input logic [7:0] b);
        int r;
        begin
            for (int k = 0; k < 2; k++)
            begin
                r = $urandom_range(99);
                if (r < 2)
                begin
                    continue;
                end
                else if (r < 5)
                begin
                    push_char(8'($urandom_range(255)));
                end
                else
                begin
                    push_char(nibble_char(k == 0 ? b[7:4] : b[3:0]));
                end
            end
        end
    endtask

    task automatic queue_frames(input int budget);
        int         base;
        int         r;
        int         lim;
        logic [7:0] len;
        begin
            base = chars_queued;
            while (chars_queued - base < budget)
            begin
                r = $urandom_range(99);
                if (r < 5)
                begin
                    len = LEN_RESET_MARK;
                end
                else if (r < 10)
                begin
                    len = LEN_ZERO;
                end
                else if (r < 15)
                begin
                    len = 8'($urandom_range(255));
                end
                else
                begin
                    lim = (buf_size >= 8'd2 && buf_size < 8'd40) ? buf_size + 2 : 24;
                    len = 8'($urandom_range(lim, 1));
                end
                push_byte(len);
                if (len != LEN_ZERO && len != LEN_RESET_MARK)
                begin
                    for (int i = 1; i < len && chars_queued - base < budget; i++)
                    begin
                        push_byte(8'($urandom_range(255)));
                    end
                end
            end
        end
    endtask

    task automatic wait_idle();
        begin
            while (char_queue.size() > 0 || char_valid || expected_bytes.size() > 0)
            begin
                @(posedge clk);
            end
            repeat (8) @(posedge clk);
        end
    endtask

    // Write buffer_size, then read it back.
    task automatic write_buffer_size(input logic [7:0] value);
        logic [31:0] rd;
        begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_BUFFER_SIZE, 2'b00};
            pwdata  <= {24'd0, value};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            rd = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            buf_size = value;
            if (rd[7:0] !== value)
            begin
                $error("buffer_size readback: expected %0d, got %0d", value, rd[7:0]);
                fail_count++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset marker, zero length, length of one, two-byte frame
        push_text("FF0001027f");
        wait_idle();

        // overrun ahead of completion, then a non-hex pair
        write_buffer_size(8'd3);
        push_text("03aBc9");
        push_char(8'h00);
        push_char(8'hFF);
        push_text("Ed");
        wait_idle();

        write_buffer_size(8'd255);
        queue_frames(170);
        wait_idle();

        write_buffer_size(8'd2);
        queue_frames(120);
        wait_idle();

        write_buffer_size(8'd0);
        queue_frames(100);
        wait_idle();

        write_buffer_size(8'd1);
        queue_frames(100);
        wait_idle();

        // full rate on both sides
        write_buffer_size(BUFFER_SIZE_INIT);
        steady = 1'b1;
        queue_frames(200);
        wait_idle();
        steady = 1'b0;

        write_buffer_size(8'($urandom_range(40, 3)));
        queue_frames(240);
        wait_idle();

        if (expected_bytes.size() != 0)
        begin
            $error("%0d byte beats never arrived", expected_bytes.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
